@@ rtl/core/olst_pkg.sv @@
// Package for the ordered list store: field widths, command codes and status codes.
// Shared by the sequencer, the entry memory and the top level; depends on nothing.
`timescale 1ns / 1ps

package olst_pkg;

    // Field widths of the command and response items.
    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 3;
    localparam int LCNT_W  = 7;

    // Default number of list entries.
    localparam int DEPTH_DEF = 64;

    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [STAT_W-1:0]        stat_t;
    typedef logic [LCNT_W-1:0]        lcnt_t;

    // Command codes.
    localparam cmd_t CMD_INSERT  = 2'd0;
    localparam cmd_t CMD_DELETE  = 2'd1;
    localparam cmd_t CMD_READ    = 2'd2;
    localparam cmd_t CMD_REVERSE = 2'd3;

    // Status codes.
    localparam stat_t ST_OK        = 3'd0;
    localparam stat_t ST_BAD_POS   = 3'd1;
    localparam stat_t ST_EMPTY     = 3'd2;
    localparam stat_t ST_NOT_FOUND = 3'd3;
    localparam stat_t ST_FULL      = 3'd4;

endpackage

@@ rtl/core/olst_mem.sv @@
// Single-port entry memory of the ordered list store, one access per cycle.
// Read data is registered. Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_mem #(
    parameter int DEPTH  = olst_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  olst_pkg::data_t   wdata,
    output olst_pkg::data_t   rdata
);
    import olst_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_reg;

    // One write or one read per cycle; the read word appears on the next cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/olst_ctrl.sv @@
// Command sequencer of the ordered list store: walks the entry memory for each
// command, keeps the live count and holds the response register. Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_ctrl #(
    parameter int DEPTH  = olst_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    // Command channel
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  olst_pkg::cmd_t    cmd,
    input  olst_pkg::pos_t    position,
    input  olst_pkg::data_t   operand_value,
    // Response channel
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output olst_pkg::stat_t   status,
    output olst_pkg::data_t   read_value,
    output olst_pkg::lcnt_t   live_count,
    // Entry memory port
    output logic              mem_en,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_addr,
    output olst_pkg::data_t   mem_wdata,
    input  olst_pkg::data_t   mem_rdata
);
    import olst_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_DEL_RD  = 4'd4;
    localparam logic [3:0] S_DEL_CMP = 4'd5;
    localparam logic [3:0] S_SH_RD   = 4'd6;
    localparam logic [3:0] S_SH_WR   = 4'd7;
    localparam logic [3:0] S_RD_CAP  = 4'd8;
    localparam logic [3:0] S_RV_CHK  = 4'd9;
    localparam logic [3:0] S_RV_RDLO = 4'd10;
    localparam logic [3:0] S_RV_RDHI = 4'd11;
    localparam logic [3:0] S_RV_WRLO = 4'd12;
    localparam logic [3:0] S_RV_WRHI = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    cmd_t             cmd_reg, cmd_next;
    pos_t             pos_reg, pos_next;
    data_t            key_reg, key_next;
    data_t            tmp_reg, tmp_next;
    stat_t            stat_reg, stat_next;
    data_t            rdv_reg, rdv_next;
    logic             rsp_valid_reg, rsp_valid_next;
    stat_t            rsp_stat_reg, rsp_stat_next;
    data_t            rsp_value_reg, rsp_value_next;
    lcnt_t            rsp_count_reg, rsp_count_next;

    logic [CMP_W-1:0] pos_ext, cnt_ext, idx_ext;
    logic [CNT_W-1:0] idx_inc, idx_dec, hi_dec;
    logic             is_full, is_empty;

    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign idx_ext  = CMP_W'(idx_reg);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign hi_dec   = hi_reg - CNT_W'(1);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Next-state and memory access logic for every command.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        hi_next        = hi_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        tmp_next       = tmp_reg;
        stat_next      = stat_reg;
        rdv_next       = rdv_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_stat_next  = rsp_stat_reg;
        rsp_value_next = rsp_value_reg;
        rsp_count_next = rsp_count_reg;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = idx_reg[ADDR_W-1:0];
        mem_wdata      = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    pos_next   = position;
                    key_next   = operand_value;
                    stat_next  = ST_OK;
                    rdv_next   = '0;
                    state_next = S_DISP;
                end
            end

            // Check the command against the count and start its walk.
            S_DISP:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (is_full)
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_DONE;
                        end
                        else if (pos_ext > cnt_ext)
                        begin
                            stat_next  = ST_BAD_POS;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (is_empty)
                        begin
                            stat_next  = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_DEL_RD;
                        end
                    end
                    CMD_READ:
                    begin
                        if (is_empty)
                        begin
                            stat_next  = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            stat_next  = ST_BAD_POS;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mem_en     = 1'b1;
                            mem_addr   = pos_ext[ADDR_W-1:0];
                            state_next = S_RD_CAP;
                        end
                    end
                    default:
                    begin
                        idx_next   = '0;
                        hi_next    = count_reg;
                        state_next = S_RV_CHK;
                    end
                endcase
            end

            // Insert: move entries up one place from the top down, then drop the value in.
            S_INS_RD:
            begin
                mem_en = 1'b1;
                if (idx_ext > pos_ext)
                begin
                    mem_addr   = idx_dec[ADDR_W-1:0];
                    state_next = S_INS_WR;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_addr   = pos_ext[ADDR_W-1:0];
                    mem_wdata  = key_reg;
                    count_next = idx_inc;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_INS_WR:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                idx_next   = idx_dec;
                state_next = S_INS_RD;
            end

            // Delete: scan for the key from the bottom.
            S_DEL_RD:
            begin
                mem_en     = 1'b1;
                state_next = S_DEL_CMP;
            end
            S_DEL_CMP:
            begin
                if (mem_rdata == key_reg)
                begin
                    state_next = S_SH_RD;
                end
                else if (idx_inc == count_reg)
                begin
                    stat_next  = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_DEL_RD;
                end
            end

            // Delete: close the gap by moving later entries down one place.
            S_SH_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    mem_en     = 1'b1;
                    mem_addr   = idx_inc[ADDR_W-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_SH_WR:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = S_SH_RD;
            end

            // Read: capture the word fetched in the dispatch cycle.
            S_RD_CAP:
            begin
                rdv_next   = mem_rdata;
                state_next = S_DONE;
            end

            // Reverse: swap the outermost pair until the indexes meet.
            S_RV_CHK:
            begin
                if (idx_inc < hi_reg)
                begin
                    hi_next    = hi_dec;
                    state_next = S_RV_RDLO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RV_RDLO:
            begin
                mem_en     = 1'b1;
                state_next = S_RV_RDHI;
            end
            S_RV_RDHI:
            begin
                mem_en     = 1'b1;
                mem_addr   = hi_reg[ADDR_W-1:0];
                tmp_next   = mem_rdata;
                state_next = S_RV_WRLO;
            end
            S_RV_WRLO:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                state_next = S_RV_WRHI;
            end
            S_RV_WRHI:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = hi_reg[ADDR_W-1:0];
                mem_wdata  = tmp_reg;
                idx_next   = idx_inc;
                state_next = S_RV_CHK;
            end

            // Hand the response to the output register once it is free.
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_stat_next  = stat_reg;
                    rsp_value_next = rdv_reg;
                    rsp_count_next = LCNT_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and response payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        hi_reg        <= hi_next;
        cmd_reg       <= cmd_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        tmp_reg       <= tmp_next;
        stat_reg      <= stat_next;
        rdv_reg       <= rdv_next;
        rsp_stat_reg  <= rsp_stat_next;
        rsp_value_reg <= rsp_value_next;
        rsp_count_reg <= rsp_count_next;
    end

    assign cmd_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_stat_reg;
    assign read_value = rsp_value_reg;
    assign live_count = rsp_count_reg;

endmodule

@@ rtl/core/ordered_list_store_unit.sv @@
// Ordered list store: top level joining the command sequencer and the entry memory.
// A read fetches the addressed entry at dispatch; a rejected command goes straight from dispatch
// to the response. Each entry move is a read then a write on the single-port entry memory,
// and a reverse swap reads the low and high entries, then writes both back crossed.
// Throughput: one item at a time; the next item is taken while a response waits in the
// output register. Reset clears the count and the response valid; entries are not cleared.
`timescale 1ns / 1ps

module ordered_list_store_unit #(
    parameter int DEPTH = olst_pkg::DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  olst_pkg::cmd_t  cmd,
    input  olst_pkg::pos_t  position,
    input  olst_pkg::data_t operand_value,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output olst_pkg::stat_t status,
    output olst_pkg::data_t read_value,
    output olst_pkg::lcnt_t live_count
);
    import olst_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    data_t             mem_wdata;
    data_t             mem_rdata;

    // Sequencer with the response register.
    olst_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .position      (position),
        .operand_value (operand_value),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .read_value    (read_value),
        .live_count    (live_count),
        .mem_en        (mem_en),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata)
    );

    // Entry storage.
    olst_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // An accepted item makes the command port drop ready straight after it is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command port ready right after an accepted item");

    // The memory is only written while a command is being worked on.
    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_en && mem_we |-> !cmd_ready)
        else $error("entry memory written while idle");

    // Any failing command returns a zero read value.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (read_value == '0))
        else $error("nonzero read value with an error status");

    // The reported count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (DEPTH < 128) |-> (32'(live_count) <= 32'(DEPTH)))
        else $error("live count above depth");

endmodule
